FILE: rtl/core/cse_pkg.sv
// Shared constants and interface types of the cosine series integrand evaluator.
`timescale 1ns / 1ps
`default_nettype none

package cse_pkg;

    localparam int MAX_M_DEF      = 16;
    localparam int MAX_N_DEF      = 16;
    localparam int COEF_DEPTH_DEF = 512;

    // Phases are kept modulo 2^60 in units of 2^-60 turn.
    localparam int PHASE_W = 60;
    // Widest angle multiple: kappa times m, both five bits.
    localparam int MULT_W  = 10;

    typedef struct packed {
        logic                      start;
        logic [MULT_W-1:0]         mult;
        logic [PHASE_W-1:0]        base;
    } cos_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [31:0]        value;
    } cos_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/cse_cos.sv
// Multi-cycle Q30 cosine unit of a phase multiple, with its own 32x32 multiplier.
`timescale 1ns / 1ps
`default_nettype none

module cse_cos (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cse_pkg::cos_req_t req,
    output cse_pkg::cos_rsp_t      rsp
);

    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

    typedef enum logic [3:0] {
        C_IDLE, C_PM, C_G, C_TH, C_Z, C_W, C_D, C_C, C_FIN
    } cstate_t;

    // Divisors of the nested Taylor form with reciprocals for a floor divide.
    function automatic logic [7:0] div_d(input logic [2:0] i);
        logic [7:0] d;
        case (i)
            3'd0:    d = 8'd132;
            3'd1:    d = 8'd90;
            3'd2:    d = 8'd56;
            3'd3:    d = 8'd30;
            3'd4:    d = 8'd12;
            default: d = 8'd2;
        endcase
        return d;
    endfunction

    function automatic logic [5:0] div_s(input logic [2:0] i);
        logic [5:0] s;
        case (i)
            3'd0:    s = 6'd38;
            3'd1:    s = 6'd37;
            3'd2:    s = 6'd36;
            3'd3:    s = 6'd35;
            3'd4:    s = 6'd34;
            default: s = 6'd32;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] div_r(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0:    r = 32'd2082408385;
            3'd1:    r = 32'd1527099483;
            3'd2:    r = 32'd1227133513;
            3'd3:    r = 32'd1145324612;
            3'd4:    r = 32'd1431655765;
            default: r = 32'd2147483648;
        endcase
        return r;
    endfunction

    cstate_t                          state_reg;
    logic [cse_pkg::PHASE_W-1:0]      base_reg;
    logic [cse_pkg::PHASE_W-1:0]      ph_reg;
    logic [cse_pkg::MULT_W-1:0]       k_reg;
    logic [3:0]                       bit_reg;
    logic [1:0]                       quad_reg;
    logic [63:0]                      p_reg;
    logic [31:0]                      z_reg;
    logic [31:0]                      w_reg;
    logic signed [31:0]               r_reg;
    logic [2:0]                       i_reg;
    logic                             done_reg;
    logic signed [31:0]               value_reg;

    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] p_next;
    logic [31:0] turn;
    logic [30:0] g_arg;
    logic [31:0] q_est;
    logic [39:0] qd;
    logic [39:0] rem;
    logic [31:0] q_fix;

    always_comb
    begin
        turn  = ph_reg[59:28];
        g_arg = turn[30] ? (Q30_ONE - {1'b0, turn[29:0]}) : {1'b0, turn[29:0]};
        case (state_reg)
            C_G:
            begin
                op_a = {1'b0, g_arg};
                op_b = HALF_PI_Q30;
            end
            C_TH:
            begin
                op_a = {1'b0, p_reg[60:30]};
                op_b = {1'b0, p_reg[60:30]};
            end
            C_W:
            begin
                op_a = z_reg;
                op_b = {1'b0, r_reg[30:0]};
            end
            C_D:
            begin
                op_a = p_reg[61:30];
                op_b = div_r(i_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        p_next = {32'd0, op_a} * {32'd0, op_b};
        q_est  = 32'(p_reg >> div_s(i_reg));
        qd     = {8'd0, q_est} * {32'd0, div_d(i_reg)};
        rem    = {8'd0, w_reg} - qd;
        // The reciprocal estimate is low by at most one.
        q_fix  = (rem >= {32'd0, div_d(i_reg)}) ? (q_est + 32'd1) : q_est;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            p_reg    <= p_next;
            done_reg <= (state_reg == C_FIN);
            case (state_reg)
                C_IDLE:
                begin
                    if (req.start)
                    begin
                        base_reg  <= req.base;
                        k_reg     <= req.mult;
                        ph_reg    <= '0;
                        bit_reg   <= 4'(cse_pkg::MULT_W - 1);
                        state_reg <= C_PM;
                    end
                end
                C_PM:
                begin
                    ph_reg <= {ph_reg[58:0], 1'b0} + (k_reg[bit_reg] ? base_reg : '0);
                    if (bit_reg == 4'd0)
                    begin
                        state_reg <= C_G;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 4'd1;
                    end
                end
                C_G:
                begin
                    quad_reg  <= turn[31:30];
                    state_reg <= C_TH;
                end
                C_TH:
                begin
                    state_reg <= C_Z;
                end
                C_Z:
                begin
                    z_reg     <= p_reg[61:30];
                    r_reg     <= 32'sh4000_0000;
                    i_reg     <= 3'd0;
                    state_reg <= C_W;
                end
                C_W:
                begin
                    state_reg <= C_D;
                end
                C_D:
                begin
                    w_reg     <= p_reg[61:30];
                    state_reg <= C_C;
                end
                C_C:
                begin
                    r_reg <= 32'sh4000_0000 - $signed(q_fix);
                    if (i_reg == 3'd5)
                    begin
                        state_reg <= C_FIN;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 3'd1;
                        state_reg <= C_W;
                    end
                end
                C_FIN:
                begin
                    value_reg <= (quad_reg == 2'd1 || quad_reg == 2'd2) ? -r_reg : r_reg;
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule

`default_nettype wire

FILE: rtl/core/cosine_series_integrand_eval.sv
// Cosine series integrand evaluator: coefficient store, series sequencer and output stage.
//
// Input channel (in_valid / in_stall): a load item writes coef_value at coef_index
// into the coefficient store in the cycle of its transfer and gives no result; a
// load beyond the store depth is dropped. An evaluate item takes phi_angle and
// gives one result on the output channel (out_valid / out_stall) with
// end_of_grid copied from last_point.
// An evaluate runs the series over N and M, the clamped mode counts, and
// the later rows count as none when M is below two; every Q30 cosine comes
// from the shared cosine unit, a first-row term needs one cosine and a later
// term three. in_stall is high while an evaluate runs.
// A finished result waits in the output register while the receiver stalls;
// the block meanwhile accepts the next item and holds a further result in its
// last step until the register frees up.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered and must
// come while the block is idle. Reset clears the control state and loads the
// register defaults; the coefficient store holds no defined value until written.
`timescale 1ns / 1ps
`default_nettype none

module cosine_series_integrand_eval #(
    parameter int MAX_M      = cse_pkg::MAX_M_DEF,
    parameter int MAX_N      = cse_pkg::MAX_N_DEF,
    parameter int COEF_DEPTH = cse_pkg::COEF_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               operation,
    input  wire logic [8:0]         coef_index,
    input  wire logic signed [31:0] coef_value,
    input  wire logic signed [31:0] phi_angle,
    input  wire logic               last_point,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [63:0]      integrand_value,
    output logic                    end_of_grid,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    localparam int AW = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [2:0] REG_M_USED   = 3'd0;
    localparam logic [2:0] REG_N_USED   = 3'd1;
    localparam logic [2:0] REG_KAPPA    = 3'd2;
    localparam logic [2:0] REG_N_SELECT = 3'd3;
    localparam logic [2:0] REG_M_SELECT = 3'd4;
    localparam logic [2:0] REG_ETA      = 3'd5;

    localparam logic [32:0] TURN_SCALE = 33'd683565276;

    typedef enum logic [4:0] {
        S_IDLE, S_PPHI, S_PETA, S_PSAVE, S_KFIRST, S_KETA, S_KC1, S_KC2,
        S_LMUL, S_LFAC, S_TMUL, S_TACC, S_KPHI, S_GMUL, S_GSH,
        S_WMUL, S_WACC, S_WDONE, S_OUT
    } state_t;

    // Configuration registers.
    logic [4:0]  m_used_reg;
    logic [4:0]  n_used_reg;
    logic [4:0]  kappa_reg;
    logic [4:0]  n_sel_reg;
    logic [4:0]  m_sel_reg;
    logic [31:0] eta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_used_reg <= 5'd15;
            n_used_reg <= 5'd15;
            kappa_reg  <= 5'd4;
            n_sel_reg  <= 5'd0;
            m_sel_reg  <= 5'd0;
            eta_reg    <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_M_USED:   m_used_reg <= cfg_data[4:0];
                REG_N_USED:   n_used_reg <= cfg_data[4:0];
                REG_KAPPA:    kappa_reg  <= cfg_data[4:0];
                REG_N_SELECT: n_sel_reg  <= cfg_data[4:0];
                REG_M_SELECT: m_sel_reg  <= cfg_data[4:0];
                REG_ETA:      eta_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    state_t                       state_reg;
    logic [31:0]                  phi_reg;
    logic                         last_reg;
    logic [cse_pkg::PHASE_W-1:0]  pphi_reg;
    logic [cse_pkg::PHASE_W-1:0]  peta_reg;
    logic [4:0]                   mm_reg;
    logic [4:0]                   nn_reg;
    logic [4:0]                   m_reg;
    logic [4:0]                   n_reg;
    logic                         first_reg;
    logic                         basis_mode_reg;
    logic [AW-1:0]                addr_reg;
    logic signed [63:0]           h_reg;
    logic signed [31:0]           ce_reg;
    logic signed [32:0]           cs_reg;
    logic signed [32:0]           fac_reg;
    logic signed [32:0]           basis_reg;
    logic signed [31:0]           cphi_reg;
    logic signed [32:0]           g_reg;
    logic [63:0]                  wa_reg;
    logic [63:0]                  wb_reg;
    logic [127:0]                 acc_reg;
    logic [1:0]                   pidx_reg;
    logic                         second_reg;
    logic                         busy_reg;
    logic signed [65:0]           mp_reg;
    logic                         out_valid_reg;
    logic signed [63:0]           integrand_reg;
    logic                         eog_reg;

    // Coefficient store.
    logic [31:0]   coef_mem [COEF_DEPTH];
    logic [31:0]   rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;

    assign in_stall  = (state_reg != S_IDLE);
    assign mem_we    = in_valid && !in_stall && (operation == OP_LOAD)
                       && ({23'd0, coef_index} < 32'(COEF_DEPTH));
    assign mem_waddr = AW'(coef_index);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            coef_mem[mem_waddr] <= coef_value;
        end
        rdata_reg <= coef_mem[addr_reg];
    end

    cse_pkg::cos_req_t cos_req;
    cse_pkg::cos_rsp_t cos_rsp;

    cse_cos u_cos (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cos_req),
        .rsp   (cos_rsp)
    );

    logic [4:0]          mm_c;
    logic [4:0]          nn_c;
    logic [4:0]          nm1;
    logic                call_state;
    logic signed [32:0]  ma;
    logic signed [32:0]  mb;
    logic signed [65:0]  mp_next;
    logic [31:0]         a_half;
    logic [31:0]         b_half;
    logic [127:0]        pp_shifted;
    logic [AW-1:0]       addr_next;
    logic signed [32:0]  w_fac;
    logic signed [32:0]  f_fac;
    logic signed [32:0]  cos_ext;
    logic [63:0]         hmag;
    logic signed [32:0]  g_abs;
    logic [63:0]         gmag;
    logic [63:0]         sq_sat;
    logic                ovf;
    logic [63:0]         val;
    logic [63:0]         val_neg;
    logic signed [63:0]  result;

    always_comb
    begin
        mm_c = (32'(m_used_reg) > MAX_M) ? 5'(MAX_M) : m_used_reg;
        nn_c = (32'(n_used_reg) > MAX_N) ? 5'(MAX_N) : n_used_reg;
        nm1  = (n_reg == 5'd0) ? 5'd1 : (n_reg - 5'd1);

        call_state = (state_reg == S_KFIRST) || (state_reg == S_KETA)
                     || (state_reg == S_KC1) || (state_reg == S_KC2)
                     || (state_reg == S_KPHI);
        cos_req.start = call_state && !busy_reg;
        cos_req.base  = (state_reg == S_KETA) ? peta_reg : pphi_reg;
        case (state_reg)
            S_KFIRST, S_KC1: cos_req.mult = {4'd0, n_reg, 1'b0};
            S_KC2:           cos_req.mult = {4'd0, nm1, 1'b0};
            S_KETA:          cos_req.mult = {5'd0, kappa_reg} * {5'd0, m_reg};
            S_KPHI:          cos_req.mult = 10'd1;
            default:         cos_req.mult = '0;
        endcase

        a_half = pidx_reg[1] ? wa_reg[63:32] : wa_reg[31:0];
        b_half = pidx_reg[0] ? wb_reg[63:32] : wb_reg[31:0];
        case (state_reg)
            S_PPHI:
            begin
                ma = {phi_reg[31], phi_reg};
                mb = TURN_SCALE;
            end
            S_PETA:
            begin
                ma = {eta_reg[31], eta_reg};
                mb = TURN_SCALE;
            end
            S_LMUL:
            begin
                ma = {ce_reg[31], ce_reg};
                mb = cs_reg;
            end
            S_TMUL:
            begin
                ma = {rdata_reg[31], rdata_reg};
                mb = fac_reg;
            end
            S_GMUL:
            begin
                ma = {cphi_reg[31], cphi_reg};
                mb = basis_reg;
            end
            S_WMUL:
            begin
                ma = $signed({1'b0, a_half});
                mb = $signed({1'b0, b_half});
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
        mp_next = ma * mb;

        case (pidx_reg)
            2'd0:    pp_shifted = {64'd0, mp_reg[63:0]};
            2'd3:    pp_shifted = {mp_reg[63:0], 64'd0};
            default: pp_shifted = {32'd0, mp_reg[63:0], 32'd0};
        endcase

        addr_next = (32'(addr_reg) == COEF_DEPTH - 1) ? '0 : (addr_reg + AW'(1));
        w_fac     = 33'(mp_reg >>> 30);
        f_fac     = n_reg[0] ? -w_fac : w_fac;
        cos_ext   = {cos_rsp.value[31], cos_rsp.value};

        hmag   = h_reg[63] ? 64'(-h_reg) : 64'(h_reg);
        g_abs  = g_reg[32] ? -g_reg : g_reg;
        gmag   = {31'd0, g_abs};
        sq_sat = (acc_reg[127:96] != 32'd0) ? '1 : acc_reg[95:32];

        ovf     = (acc_reg[127:94] != '0);
        val     = acc_reg[93:30];
        val_neg = (ovf || val > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : val;
        if (!g_reg[32])
        begin
            result = (ovf || val[63]) ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(val);
        end
        else
        begin
            result = $signed(-val_neg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            addr_reg      <= '0;
        end
        else
        begin
            mp_reg <= mp_next;
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            if (call_state)
            begin
                if (!busy_reg)
                begin
                    busy_reg <= 1'b1;
                end
                else if (cos_rsp.done)
                begin
                    busy_reg <= 1'b0;
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && operation == OP_EVAL)
                    begin
                        phi_reg   <= phi_angle;
                        last_reg  <= last_point;
                        state_reg <= S_PPHI;
                    end
                end
                S_PPHI:
                begin
                    state_reg <= S_PETA;
                end
                S_PETA:
                begin
                    pphi_reg  <= mp_reg[59:0];
                    state_reg <= S_PSAVE;
                end
                S_PSAVE:
                begin
                    peta_reg       <= mp_reg[59:0];
                    h_reg          <= '0;
                    addr_reg       <= '0;
                    n_reg          <= 5'd0;
                    m_reg          <= 5'd0;
                    first_reg      <= 1'b1;
                    basis_mode_reg <= 1'b0;
                    mm_reg         <= mm_c;
                    nn_reg         <= nn_c;
                    state_reg      <= S_KFIRST;
                end
                S_KFIRST:
                begin
                    if (busy_reg && cos_rsp.done)
                    begin
                        if (basis_mode_reg)
                        begin
                            basis_reg <= cos_ext;
                            state_reg <= S_KPHI;
                        end
                        else
                        begin
                            fac_reg   <= cos_ext;
                            state_reg <= S_TMUL;
                        end
                    end
                end
                S_KETA:
                begin
                    if (busy_reg && cos_rsp.done)
                    begin
                        ce_reg    <= cos_rsp.value;
                        state_reg <= S_KC1;
                    end
                end
                S_KC1:
                begin
                    if (busy_reg && cos_rsp.done)
                    begin
                        cs_reg    <= cos_ext;
                        state_reg <= S_KC2;
                    end
                end
                S_KC2:
                begin
                    if (busy_reg && cos_rsp.done)
                    begin
                        cs_reg    <= cs_reg + cos_ext;
                        state_reg <= S_LMUL;
                    end
                end
                S_LMUL:
                begin
                    state_reg <= S_LFAC;
                end
                S_LFAC:
                begin
                    if (basis_mode_reg)
                    begin
                        basis_reg <= f_fac;
                        state_reg <= S_KPHI;
                    end
                    else
                    begin
                        fac_reg   <= f_fac;
                        state_reg <= S_TMUL;
                    end
                end
                S_TMUL:
                begin
                    state_reg <= S_TACC;
                end
                S_TACC:
                begin
                    h_reg    <= h_reg + 64'(mp_reg >>> 22);
                    addr_reg <= addr_next;
                    if (n_reg != nn_reg)
                    begin
                        n_reg     <= n_reg + 5'd1;
                        state_reg <= first_reg ? S_KFIRST : S_KETA;
                    end
                    else if (first_reg && mm_reg >= 5'd2 && nn_reg != 5'd0)
                    begin
                        first_reg <= 1'b0;
                        m_reg     <= 5'd1;
                        n_reg     <= 5'd1;
                        state_reg <= S_KETA;
                    end
                    else if (!first_reg && ({1'b0, m_reg} + 6'd2 <= {1'b0, mm_reg}))
                    begin
                        m_reg     <= m_reg + 5'd1;
                        n_reg     <= 5'd1;
                        state_reg <= S_KETA;
                    end
                    else
                    begin
                        // Series done: the selected basis term comes next.
                        basis_mode_reg <= 1'b1;
                        m_reg          <= m_sel_reg;
                        n_reg          <= n_sel_reg;
                        state_reg      <= (m_sel_reg == 5'd0) ? S_KFIRST : S_KETA;
                    end
                end
                S_KPHI:
                begin
                    if (busy_reg && cos_rsp.done)
                    begin
                        cphi_reg  <= cos_rsp.value;
                        state_reg <= S_GMUL;
                    end
                end
                S_GMUL:
                begin
                    state_reg <= S_GSH;
                end
                S_GSH:
                begin
                    g_reg      <= w_fac;
                    wa_reg     <= hmag;
                    wb_reg     <= hmag;
                    acc_reg    <= '0;
                    pidx_reg   <= 2'd0;
                    second_reg <= 1'b0;
                    state_reg  <= S_WMUL;
                end
                S_WMUL:
                begin
                    state_reg <= S_WACC;
                end
                S_WACC:
                begin
                    acc_reg <= acc_reg + pp_shifted;
                    if (pidx_reg == 2'd3)
                    begin
                        state_reg <= S_WDONE;
                    end
                    else
                    begin
                        pidx_reg  <= pidx_reg + 2'd1;
                        state_reg <= S_WMUL;
                    end
                end
                S_WDONE:
                begin
                    if (!second_reg)
                    begin
                        wa_reg     <= sq_sat;
                        wb_reg     <= gmag;
                        acc_reg    <= '0;
                        pidx_reg   <= 2'd0;
                        second_reg <= 1'b1;
                        state_reg  <= S_WMUL;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        integrand_reg <= result;
                        eog_reg       <= last_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign integrand_value = integrand_reg;
    assign end_of_grid     = eog_reg;

`ifndef SYNTHESIS
    // A cosine answer only comes back to a call that is waiting for it.
    assert property (@(posedge clk) disable iff (!rst_n) cos_rsp.done |-> busy_reg)
        else $error("cosine unit answered without a pending call");

    // No cosine call stays open once the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n) (state_reg == S_IDLE) |-> !busy_reg)
        else $error("cosine call left open in idle");

    // A new result only appears from the output step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    // The series read address stays inside the store.
    assert property (@(posedge clk) disable iff (!rst_n) 32'(addr_reg) < COEF_DEPTH)
        else $error("coefficient address out of range");
`endif

endmodule

`default_nettype wire
